// File: src/psrns_pkg.sv
// Shared types and constants of the point store radius neighbor scan block.
package psrns_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int CNT_W        = 6;
   localparam int COORD_W      = 16;
   localparam int DIST_W       = 33;
   localparam int SQ_W         = 32;
   localparam int MODE_W       = 2;
   localparam int CSR_IDX_W    = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   localparam logic KIND_NEIGHBOR   = 1'b0;
   localparam logic KIND_COMPLETION = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_DUP_DIST_SQ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS_SQ   = 2'd1;

   localparam logic [DIST_W-1:0] DUP_DIST_SQ_RESET = 33'd1;
   localparam logic [DIST_W-1:0] RADIUS_SQ_RESET   = 33'd1048576;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [COORD_W-1:0] point_x_in;
      logic signed [COORD_W-1:0] point_y_in;
      logic                      collect_neighbors;
   } req_type;

   typedef struct packed {
      logic                      kind;
      logic signed [COORD_W-1:0] neighbor_x;
      logic signed [COORD_W-1:0] neighbor_y;
      logic                      is_duplicate;
      logic                      closest_valid;
      logic signed [COORD_W-1:0] closest_x;
      logic signed [COORD_W-1:0] closest_y;
      logic [DIST_W-1:0]         closest_dist_sq;
      logic [CNT_W-1:0]          neighbor_total;
      logic                      insert_accepted;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [DIST_W-1:0]         dist_sq;
   } dist_type;

endpackage

// File: src/psrns_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module psrns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/psrns_dist.sv
// Squared-distance stage: squares the coordinate differences of one stored point.
module psrns_dist
   import psrns_pkg::*;
(
   input  logic                      clock,
   input  logic                      en,
   input  logic [2*COORD_W-1:0]      point,
   input  logic signed [COORD_W-1:0] qx,
   input  logic signed [COORD_W-1:0] qy,
   output dist_type                  result
);

   logic signed [COORD_W-1:0] px_ff, py_ff, px_in, py_in;
   logic [SQ_W-1:0]           sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic signed [COORD_W:0]   dx, dy;
   logic signed [2*COORD_W+1:0] prod_x, prod_y;

   always_comb begin
      px_in  = point[COORD_W-1:0];
      py_in  = point[2*COORD_W-1:COORD_W];
      dx     = {px_in[COORD_W-1], px_in} - {qx[COORD_W-1], qx};
      dy     = {py_in[COORD_W-1], py_in} - {qy[COORD_W-1], qy};
      prod_x = dx * dx;
      prod_y = dy * dy;
      // The square of a 17-bit difference never exceeds 32 bits.
      sqx_in = prod_x[SQ_W-1:0];
      sqy_in = prod_y[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
      end
   end

   assign result.x       = px_ff;
   assign result.y       = py_ff;
   assign result.dist_sq = {1'b0, sqx_ff} + {1'b0, sqy_ff};

endmodule

// File: src/point_store_radius_neighbor_scan_core.sv
// Top level of the point store with brute-force radius neighbor scan.
//
// Requests arrive on the req_ valid/ready channel: insert a point, query a
// point, or clear the store. Results leave on the rsp_ valid/ready channel;
// every request ends with one completion result marked last, and a query may
// first emit one neighbor result for each stored point inside the radius. The user must
// write both thresholds via csr_ only while the block is idle; the block does not check.
//
// One request is worked on at a time. Insert, clear and the unused mode pass
// through FINISH, which loads their completion into the result register once
// it is free. A query streams the stored points out of the point RAM at one per
// cycle while the result register is free, through a three-stage read, square
// and compare pipeline, and loads its completion in FINISH. The single RAM
// read port sets that rate; a duplicate ends the scan early.
//
// The result register decouples the two sides: a new request is accepted
// while the previous completion still waits to be taken. When the receiver
// stalls with a result pending, the whole scan pipeline holds in place.
// Reset empties the store, restores the thresholds and drops any pending
// result; the point RAM itself is not cleared.
module point_store_radius_neighbor_scan_core
   import psrns_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIST_W-1:0]    csr_wdata
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [DIST_W-1:0] dup_thr_ff, dup_thr_in, radius_ff, radius_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              vb_ff, vb_in, vc_ff, vc_in;
   logic              dup_ff, dup_in, have_ff, have_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic signed [COORD_W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              slot_free;
   logic              issue;
   logic              wr_en;
   logic [2*COORD_W-1:0] rd_data;
   dist_type          cand;

   // The result register is free when empty or being taken this cycle;
   // every pipeline stage advances only then.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign issue     = (state_ff == ST_SCAN) && slot_free && (rd_idx_ff < count_ff);

   // The FSM never reads and writes the RAM in the same request phase:
   // writes happen only in FINISH of an insert, reads only during SCAN.
   psrns_ram #(
      .WIDTH (2*COORD_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_ff.point_y_in, req_ff.point_x_in}),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   psrns_dist u_dist (
      .clock  (clock),
      .en     ((state_ff == ST_SCAN) && slot_free),
      .point  (rd_data),
      .qx     (req_ff.point_x_in),
      .qy     (req_ff.point_y_in),
      .result (cand)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      dup_thr_in   = dup_thr_ff;
      radius_in    = radius_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      vb_in        = vb_ff;
      vc_in        = vc_ff;
      dup_in       = dup_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            REG_DUP_DIST_SQ: dup_thr_in = csr_wdata;
            REG_RADIUS_SQ:   radius_in  = csr_wdata;
            default:         ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               rd_idx_in = '0;
               vb_in     = 1'b0;
               vc_in     = 1'b0;
               dup_in    = 1'b0;
               have_in   = 1'b0;
               best_in   = '0;
               bx_in     = '0;
               by_in     = '0;
               total_in  = '0;
               state_in  = (req_data.mode == MODE_QUERY) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (slot_free) begin
               vb_in = issue;
               vc_in = vb_ff;
               if (issue) begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
               if (vc_ff) begin
                  if (cand.dist_sq < dup_thr_ff) begin
                     // Duplicate: drop everything in flight and complete.
                     dup_in   = 1'b1;
                     vb_in    = 1'b0;
                     vc_in    = 1'b0;
                     state_in = ST_FINISH;
                  end else if (req_ff.collect_neighbors) begin
                     if (!have_ff || (cand.dist_sq < best_ff)) begin
                        have_in = 1'b1;
                        best_in = cand.dist_sq;
                        bx_in   = cand.x;
                        by_in   = cand.y;
                     end
                     if (cand.dist_sq < radius_ff) begin
                        rsp_valid_in      = 1'b1;
                        rsp_in            = '0;
                        rsp_in.kind       = KIND_NEIGHBOR;
                        rsp_in.neighbor_x = cand.x;
                        rsp_in.neighbor_y = cand.y;
                        total_in          = total_ff + 1'b1;
                     end
                  end
               end else if (!vb_ff && (rd_idx_ff >= count_ff)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.kind  = KIND_COMPLETION;
               rsp_in.last  = 1'b1;
               case (req_ff.mode)
                  MODE_INSERT: begin
                     if (count_ff < CAP_CNT) begin
                        wr_en                  = 1'b1;
                        count_in               = count_ff + 1'b1;
                        rsp_in.insert_accepted = 1'b1;
                     end
                  end
                  MODE_QUERY: begin
                     rsp_in.is_duplicate   = dup_ff;
                     rsp_in.neighbor_total = total_ff;
                     if (have_ff && !dup_ff) begin
                        rsp_in.closest_valid   = 1'b1;
                        rsp_in.closest_x       = bx_ff;
                        rsp_in.closest_y       = by_ff;
                        rsp_in.closest_dist_sq = best_ff;
                     end
                  end
                  MODE_CLEAR: count_in = '0;
                  default:    ;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dup_thr_ff   <= DUP_DIST_SQ_RESET;
         radius_ff    <= RADIUS_SQ_RESET;
         count_ff     <= '0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dup_thr_ff   <= dup_thr_in;
         radius_ff    <= radius_in;
         count_ff     <= count_in;
         vb_ff        <= vb_in;
         vc_ff        <= vc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rd_idx_ff <= rd_idx_in;
      dup_ff    <= dup_in;
      have_ff   <= have_in;
      best_ff   <= best_in;
      bx_ff     <= bx_in;
      by_ff     <= by_in;
      total_ff  <= total_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/psrns_checker.sv
// Port-level checker for the point store scan core, bound to the top level.
module psrns_port_checks
   import psrns_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // Reset drops any pending result.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Only one request is in work at a time.
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted back to back");

   // A pending neighbor result means the query is still in work.
   a_neighbor_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_NEIGHBOR) |-> !req_ready && !rsp_data.last)
      else $error("neighbor result outside a running query");

endmodule

bind point_store_radius_neighbor_scan_core psrns_port_checks u_psrns_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
